// ===== hw/rtl/ota_pkg.sv =====
// Shared types and constants for the occupancy table assigner.
package ota_pkg;

    localparam int NumCustomersDef = 64;
    localparam int ListDepthDef    = 128;

    // occupancy counters saturate at the top of their range
    localparam int         OccW   = 7;
    localparam logic [6:0] OccMax = 7'd127;

    localparam int MemberW = 7;

    typedef enum logic [2:0] {
        CMD_UNLINK = 3'd0,
        CMD_LINK   = 3'd1,
        CMD_CREATE = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_LOOKUP = 3'd4,
        CMD_READ   = 3'd5,
        CMD_SIZE   = 3'd6
    } t_cmd;

endpackage

// ===== hw/rtl/occupancy_table_assigner_core.sv =====
// Occupancy table assigner: customer-to-table map, occupancy counts and active table list.

// One request is taken at a time; a new request is taken while the previous result
// still waits at the output. Unlink and link do a read-modify-write of the customer
// entry, then of the target table count; unlink of an unseated customer skips the
// count. A rejected request (out of range, full or empty list, unused code) ends
// before any scan. Size, create and remove scan one entry at a time through the
// single read port of the seat memory (customer entry and table count share one word)
// or the list memory; when remove takes an entry out, it then shifts the later list
// entries down one at a time. After reset an initial pass over every customer entry
// loads the initial map and list; no request is taken until it ends.
module occupancy_table_assigner_core #(
    parameter int CUST_COUNT = ota_pkg::NumCustomersDef,
    parameter int LIST_DEPTH = ota_pkg::ListDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_cmd,
    input  logic [5:0] i_customer,
    input  logic [5:0] i_table_req,
    input  logic [6:0] i_position,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [5:0] o_table_id,
    output logic       o_assigned,
    output logic       o_in_table,
    output logic [6:0] o_member_count,
    output logic [7:0] o_active_count,
    output logic       o_ok
);

    import ota_pkg::*;

    localparam int SAW     = $clog2(CUST_COUNT);
    localparam int LAW     = $clog2(LIST_DEPTH);
    localparam int LW      = $clog2(LIST_DEPTH + 1);
    localparam int MaxD    = (CUST_COUNT > LIST_DEPTH) ? CUST_COUNT : LIST_DEPTH;
    localparam int IW      = $clog2(MaxD + 1);
    localparam int CW      = ((IW > LW) ? IW : LW) + 1;
    localparam int CmpW    = (SAW > 6) ? SAW : 6;
    localparam int LenInit = (CUST_COUNT < LIST_DEPTH) ? CUST_COUNT : LIST_DEPTH;

    typedef struct packed {
        logic            valid;
        logic [SAW-1:0]  tbl;
        logic [OccW-1:0] occ;
    } t_seat;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_SEAT_Q,
        S_OCC_RD,
        S_OCC_Q,
        S_CR_RD,
        S_CR_Q,
        S_RM_RDL,
        S_RM_LQ,
        S_RM_SQ,
        S_CP,
        S_CP_Q,
        S_LS_Q,
        S_SZ_RD,
        S_SZ_Q
    } t_state;

    // output stage is a separate flag so the FSM can finish into it
    t_state r_state;
    logic   r_resp;

    t_cmd           r_cmd;
    logic [5:0]     r_cust;
    logic [5:0]     r_treq;
    logic [6:0]     r_pos;
    logic [IW-1:0]  r_idx;
    logic [LW-1:0]  r_len;
    logic [SAW-1:0] r_tgt;

    logic [SAW-1:0]     r_res_tbl;
    logic               r_res_asg;
    logic               r_res_in;
    logic [MemberW-1:0] r_res_cnt;
    logic               r_res_ok;

    logic               r_o_valid;
    logic [5:0]         r_o_table_id;
    logic               r_o_assigned;
    logic               r_o_in_table;
    logic [MemberW-1:0] r_o_member_count;
    logic [7:0]         r_o_active_count;
    logic               r_o_ok;

    // memories
    t_seat          r_seat_mem [CUST_COUNT];
    logic [SAW-1:0] r_list_mem [LIST_DEPTH];
    t_seat          r_seat_rd;
    logic [SAW-1:0] r_list_rd;

    logic [SAW-1:0] seat_raddr;
    logic           seat_we;
    logic [SAW-1:0] seat_waddr;
    t_seat          seat_wdata;
    logic [LAW-1:0] list_raddr;
    logic           list_we;
    logic [LAW-1:0] list_waddr;
    logic [SAW-1:0] list_wdata;

    logic          cust_ok;
    logic          treq_ok;
    logic          pos_ok;
    logic          occ_zero;
    logic          tbl_match;
    logic          idx_last_cust;
    logic          idx_next_in_list;
    logic [IW-1:0] idx_inc;

    assign cust_ok          = int'(r_cust) < CUST_COUNT;
    assign treq_ok          = int'(r_treq) < CUST_COUNT;
    assign pos_ok           = CW'(r_pos) < CW'(r_len);
    assign occ_zero         = (r_seat_rd.occ == '0);
    assign tbl_match        = (CmpW'(r_seat_rd.tbl) == CmpW'(r_treq));
    assign idx_inc          = r_idx + IW'(1);
    assign idx_last_cust    = (r_idx == IW'(CUST_COUNT - 1));
    assign idx_next_in_list = (CW'(r_idx) + CW'(1)) < CW'(r_len);

    always_ff @(posedge i_clk) begin
        if (seat_we) begin
            r_seat_mem[seat_waddr] <= seat_wdata;
        end
        r_seat_rd <= r_seat_mem[seat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (list_we) begin
            r_list_mem[list_waddr] <= list_wdata;
        end
        r_list_rd <= r_list_mem[list_raddr];
    end

    always_comb begin
        seat_raddr = '0;
        seat_we    = 1'b0;
        seat_waddr = '0;
        seat_wdata = '0;
        list_raddr = '0;
        list_we    = 1'b0;
        list_waddr = '0;
        list_wdata = '0;
        // no memory traffic while a finished result waits for the output stage
        if (!r_resp) begin
            unique case (r_state)
                S_INIT: begin
                    seat_we          = 1'b1;
                    seat_waddr       = r_idx[SAW-1:0];
                    seat_wdata.valid = 1'b1;
                    seat_wdata.tbl   = r_idx[SAW-1:0];
                    seat_wdata.occ   = OccW'(1);
                    list_we          = r_idx < IW'(LenInit);
                    list_waddr       = r_idx[LAW-1:0];
                    list_wdata       = r_idx[SAW-1:0];
                end
                S_START: begin
                    seat_raddr = SAW'(r_cust);
                    list_raddr = LAW'(r_pos);
                end
                S_SEAT_Q: begin
                    seat_waddr = SAW'(r_cust);
                    seat_wdata = r_seat_rd;
                    if (r_cmd == CMD_UNLINK) begin
                        seat_we          = 1'b1;
                        seat_wdata.valid = 1'b0;
                        seat_wdata.tbl   = '0;
                    end else if (r_cmd == CMD_LINK) begin
                        seat_we          = 1'b1;
                        seat_wdata.valid = 1'b1;
                        seat_wdata.tbl   = SAW'(r_treq);
                    end
                end
                S_OCC_RD: begin
                    seat_raddr = r_tgt;
                end
                S_OCC_Q: begin
                    seat_we    = 1'b1;
                    seat_waddr = r_tgt;
                    seat_wdata = r_seat_rd;
                    if (r_cmd == CMD_LINK) begin
                        if (r_seat_rd.occ != OccMax) begin
                            seat_wdata.occ = r_seat_rd.occ + OccW'(1);
                        end
                    end else if (!occ_zero) begin
                        seat_wdata.occ = r_seat_rd.occ - OccW'(1);
                    end
                end
                S_CR_RD, S_SZ_RD: begin
                    seat_raddr = r_idx[SAW-1:0];
                end
                S_CR_Q: begin
                    list_we    = occ_zero;
                    list_waddr = r_len[LAW-1:0];
                    list_wdata = r_idx[SAW-1:0];
                end
                S_RM_RDL: begin
                    list_raddr = r_idx[LAW-1:0];
                end
                S_RM_LQ: begin
                    seat_raddr = r_list_rd;
                end
                S_CP: begin
                    list_raddr = idx_inc[LAW-1:0];
                end
                S_CP_Q: begin
                    list_we    = 1'b1;
                    list_waddr = r_idx[LAW-1:0];
                    list_wdata = r_list_rd;
                end
                S_IDLE, S_RM_SQ, S_LS_Q, S_SZ_Q: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_resp    <= 1'b0;
            r_idx     <= '0;
            r_len     <= LW'(LenInit);
            r_o_valid <= 1'b0;
        end else begin
            // finished result moves into the output register once it is free
            if (r_resp && (!r_o_valid || i_ready)) begin
                r_resp           <= 1'b0;
                r_o_valid        <= 1'b1;
                r_o_table_id     <= 6'(r_res_tbl);
                r_o_assigned     <= r_res_asg;
                r_o_in_table     <= r_res_in;
                r_o_member_count <= r_res_cnt;
                r_o_active_count <= 8'(r_len);
                r_o_ok           <= r_res_ok;
                r_state          <= S_IDLE;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            // the FSM holds while a finished result waits
            if (!r_resp) begin
                unique case (r_state)
                    S_INIT: begin
                        r_idx <= idx_inc;
                        if (idx_last_cust) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_valid) begin
                            r_cmd   <= t_cmd'(i_cmd);
                            r_cust  <= i_customer;
                            r_treq  <= i_table_req;
                            r_pos   <= i_position;
                            r_state <= S_START;
                        end
                    end
                    S_START: begin
                        r_res_tbl <= '0;
                        r_res_asg <= 1'b0;
                        r_res_in  <= 1'b0;
                        r_res_cnt <= '0;
                        r_res_ok  <= 1'b0;
                        r_idx     <= '0;
                        unique case (r_cmd)
                            CMD_UNLINK, CMD_LOOKUP: begin
                                if (cust_ok) begin
                                    r_state <= S_SEAT_Q;
                                end else begin
                                    r_resp <= 1'b1;
                                end
                            end
                            CMD_LINK: begin
                                if (cust_ok && treq_ok) begin
                                    r_state <= S_SEAT_Q;
                                end else begin
                                    r_resp <= 1'b1;
                                end
                            end
                            CMD_CREATE: begin
                                if (r_len < LW'(LIST_DEPTH)) begin
                                    r_state <= S_CR_RD;
                                end else begin
                                    r_resp <= 1'b1;
                                end
                            end
                            CMD_REMOVE: begin
                                if (r_len != '0) begin
                                    r_state <= S_RM_RDL;
                                end else begin
                                    r_resp <= 1'b1;
                                end
                            end
                            CMD_READ: begin
                                if (pos_ok) begin
                                    r_state <= S_LS_Q;
                                end else begin
                                    r_resp <= 1'b1;
                                end
                            end
                            CMD_SIZE: begin
                                r_state <= S_SZ_RD;
                            end
                            default: begin
                                r_resp <= 1'b1;
                            end
                        endcase
                    end
                    S_SEAT_Q: begin
                        priority case (r_cmd)
                            CMD_LOOKUP: begin
                                r_res_ok <= 1'b1;
                                if (r_seat_rd.valid) begin
                                    r_res_asg <= 1'b1;
                                    r_res_tbl <= r_seat_rd.tbl;
                                    r_res_in  <= tbl_match;
                                end
                                r_resp <= 1'b1;
                            end
                            CMD_UNLINK: begin
                                r_res_ok <= 1'b1;
                                r_tgt    <= r_seat_rd.tbl;
                                if (r_seat_rd.valid) begin
                                    r_state <= S_OCC_RD;
                                end else begin
                                    r_resp <= 1'b1;
                                end
                            end
                            default: begin
                                r_res_ok <= 1'b1;
                                r_tgt    <= SAW'(r_treq);
                                r_state  <= S_OCC_RD;
                            end
                        endcase
                    end
                    S_OCC_RD: begin
                        r_state <= S_OCC_Q;
                    end
                    S_OCC_Q: begin
                        r_resp <= 1'b1;
                    end
                    S_CR_RD: begin
                        r_state <= S_CR_Q;
                    end
                    S_CR_Q: begin
                        if (occ_zero) begin
                            r_len     <= r_len + LW'(1);
                            r_res_tbl <= r_idx[SAW-1:0];
                            r_res_ok  <= 1'b1;
                            r_resp    <= 1'b1;
                        end else if (idx_last_cust) begin
                            r_resp <= 1'b1;
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= S_CR_RD;
                        end
                    end
                    S_RM_RDL: begin
                        r_state <= S_RM_LQ;
                    end
                    S_RM_LQ: begin
                        r_tgt   <= r_list_rd;
                        r_state <= S_RM_SQ;
                    end
                    S_RM_SQ: begin
                        if (occ_zero) begin
                            r_res_tbl <= r_tgt;
                            r_res_ok  <= 1'b1;
                            r_state   <= S_CP;
                        end else if (!idx_next_in_list) begin
                            r_resp <= 1'b1;
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= S_RM_RDL;
                        end
                    end
                    S_CP: begin
                        // close the gap one entry at a time
                        if (idx_next_in_list) begin
                            r_state <= S_CP_Q;
                        end else begin
                            r_len  <= r_len - LW'(1);
                            r_resp <= 1'b1;
                        end
                    end
                    S_CP_Q: begin
                        r_idx   <= idx_inc;
                        r_state <= S_CP;
                    end
                    S_LS_Q: begin
                        r_res_tbl <= r_list_rd;
                        r_res_ok  <= 1'b1;
                        r_resp    <= 1'b1;
                    end
                    S_SZ_RD: begin
                        r_state <= S_SZ_Q;
                    end
                    S_SZ_Q: begin
                        if (r_seat_rd.valid && tbl_match && (r_res_cnt != '1)) begin
                            r_res_cnt <= r_res_cnt + MemberW'(1);
                        end
                        if (idx_last_cust) begin
                            r_res_ok <= 1'b1;
                            r_resp   <= 1'b1;
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= S_SZ_RD;
                        end
                    end
                endcase
            end
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_table_id     = r_o_table_id;
    assign o_assigned     = r_o_assigned;
    assign o_in_table     = r_o_in_table;
    assign o_member_count = r_o_member_count;
    assign o_active_count = r_o_active_count;
    assign o_ok           = r_o_ok;

endmodule
